/* design/page_bitmap_blit_defines.svh */
// assertion macros for the checker file pbb_checker.sv
`ifndef PAGE_BITMAP_BLIT_DEFINES_SVH
`define PAGE_BITMAP_BLIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PBB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("page_bitmap_blit: same-cycle check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define PBB_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("page_bitmap_blit: next-cycle check failed");

`endif

/* design/pbb_pkg.sv */
package pbb_pkg;

    localparam int ADDR_W = 10;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_BLIT  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_WRITE = 2'd3;

    typedef struct packed {
        logic [1:0]        command;
        logic [ADDR_W-1:0] address;
        logic [7:0]        data;
        logic [7:0]        x_pos;
        logic [5:0]        y_pos;
        logic [7:0]        blit_width;
        logic [6:0]        blit_height;
    } pbb_cmd_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [1:0] done_kind;
    } pbb_result_t;

    // control for the merge unit
    typedef struct packed {
        logic       last_page;
        logic [2:0] tail;
        logic [2:0] shift;
        logic       upper;
    } pbb_merge_ctrl_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRAP,
        ST_FWRITE,
        ST_FRD1,
        ST_FRD2,
        ST_BSETUP,
        ST_BCOL,
        ST_BRD,
        ST_BLO,
        ST_BHI
    } pbb_state_t;

    // keeps the low tail rows of a byte
    function automatic logic [7:0] tail_mask(input logic [2:0] tail);
        logic [3:0] drop;
        drop = 4'd8 - {1'b0, tail};
        return 8'(8'hff >> drop);
    endfunction

endpackage

/* design/pbb_merge.sv */
module pbb_merge
(
    input  logic [7:0]               asset_byte,
    input  logic [7:0]               frame_byte,
    input  pbb_pkg::pbb_merge_ctrl_t ctrl,
    output logic [7:0]               merged
);

    logic [7:0]  mask;
    logic [7:0]  masked;
    logic [15:0] shifted;
    logic [7:0]  part;

    always_comb
    begin
        if (ctrl.last_page && (ctrl.tail != 3'd0))
        begin
            mask = pbb_pkg::tail_mask(ctrl.tail);
        end
        else
        begin
            mask = 8'hff;
        end
        masked  = asset_byte & mask;
        shifted = {8'h00, masked} << ctrl.shift;
        // upper half lands in the next page down
        part    = ctrl.upper ? shifted[15:8] : shifted[7:0];
        merged  = frame_byte | part;
    end

endmodule

/* design/page_bitmap_blit.sv */
// page_bitmap_blit: monochrome OR-blit engine for a page-organized frame buffer
// (COLUMNS columns by PAGES pages, 8 vertical pixels per byte, bit 0 on top).
// request channel: a word is taken at a rising edge with start high and busy
// low; the engine then stays busy until the word is fully handled.
// result channel: done pulses for one cycle with read_data and done_kind;
// the receiver cannot stall, so the word must be captured in that cycle.
// states from accept to done high, shaped by the single read port of the
// frame memory: write frame byte ST_FWRITE; read frame byte ST_FRD1, ST_FRD2;
// load asset byte ST_WRAP, held while the address is past ASSET_BYTES;
// blit ST_BSETUP, then per visible column ST_BCOL, then per asset byte ST_BRD
// and ST_BLO, plus ST_BHI when the byte is split; a last ST_BCOL ends it.
// a new word can be taken in the same cycle that done is high.
// after reset the engine clears all COLUMNS*PAGES bytes of the frame memory,
// one byte a cycle, with busy high; the asset store is not cleared.
module page_bitmap_blit
#(
    parameter int COLUMNS     = 128,
    parameter int PAGES       = 8,
    parameter int ASSET_BYTES = 1024
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  pbb_pkg::pbb_cmd_t    request,
    output logic                 done,
    output pbb_pkg::pbb_result_t result
);

    localparam int FRAME_BYTES = COLUMNS * PAGES;
    localparam int FA_W        = $clog2(FRAME_BYTES);
    localparam int AA_W        = $clog2(ASSET_BYTES);
    // address compare widths, one spare bit so the bound itself fits
    localparam int FX_W   = ((FA_W > pbb_pkg::ADDR_W) ? FA_W : pbb_pkg::ADDR_W) + 1;
    localparam int WX_W   = ((AA_W > pbb_pkg::ADDR_W) ? AA_W : pbb_pkg::ADDR_W) + 1;
    // asset index and column base during a blit stay below 2^13
    localparam int AI_W   = 13;
    localparam int BASE_W = 13;

    // sequencer
    pbb_pkg::pbb_state_t state_reg, state_next;

    // captured word and loop counters
    pbb_pkg::pbb_cmd_t   item_reg, item_next;
    logic [WX_W-1:0]     wrap_reg, wrap_next;
    logic [FA_W-1:0]     clr_reg, clr_next;
    logic [7:0]          col_cnt_reg, col_cnt_next;
    logic [8:0]          col_reg, col_next;
    logic [BASE_W-1:0]   base_reg, base_next;
    logic [AI_W-1:0]     aidx_reg, aidx_next;
    logic [4:0]          page_reg, page_next;

    // result word
    logic                 done_reg, done_next;
    pbb_pkg::pbb_result_t result_reg, result_next;

    // memories, read data registered
    logic [7:0] frame_mem [FRAME_BYTES];
    logic [7:0] asset_mem [ASSET_BYTES];
    logic [7:0] frame_q;
    logic [7:0] asset_q;

    logic            fr_re, fr_we;
    logic [FA_W-1:0] fr_raddr, fr_waddr;
    logic [7:0]      fr_wdata;
    logic            as_re, as_we;
    logic [AA_W-1:0] as_raddr, as_waddr;
    logic [7:0]      as_wdata;

    // decoded blit geometry
    logic [7:0]      h_round;
    logic [4:0]      npages;
    logic [5:0]      dpage;
    logic [5:0]      dpage_hi;
    logic            last_page;
    logic            aidx_ok;
    logic            lo_ok;
    logic            hi_need;
    logic            col_end;
    logic [BASE_W-1:0] ix_lo;
    logic [BASE_W-1:0] ix_hi;

    // frame address check for single-byte access
    logic [FX_W-1:0] fx;
    logic            addr_ok;
    logic            wrap_ge;

    // merge unit
    pbb_pkg::pbb_merge_ctrl_t mctrl;
    logic [7:0]               merged;

    always_comb
    begin
        h_round   = {1'b0, item_reg.blit_height} + 8'd7;
        npages    = h_round[7:3];
        dpage     = {3'd0, item_reg.y_pos[5:3]} + {1'b0, page_reg};
        dpage_hi  = dpage + 6'd1;
        last_page = (page_reg == (npages - 5'd1));
        aidx_ok   = (aidx_reg < AI_W'(ASSET_BYTES));
        lo_ok     = (dpage < 6'(PAGES));
        // lower half of a split byte, dropped past the last page
        hi_need   = aidx_ok && (item_reg.y_pos[2:0] != 3'd0) && (dpage_hi < 6'(PAGES));
        col_end   = (col_cnt_reg == item_reg.blit_width) || (col_reg >= 9'(COLUMNS))
                    || (npages == 5'd0);
        ix_lo     = base_reg + BASE_W'(dpage);
        ix_hi     = base_reg + BASE_W'(dpage_hi);
        fx        = FX_W'(item_reg.address);
        addr_ok   = (fx < FX_W'(FRAME_BYTES));
        wrap_ge   = (wrap_reg >= WX_W'(ASSET_BYTES));
    end

    assign mctrl.last_page = last_page;
    assign mctrl.tail      = item_reg.blit_height[2:0];
    assign mctrl.shift     = item_reg.y_pos[2:0];
    assign mctrl.upper     = (state_reg == pbb_pkg::ST_BHI);

    pbb_merge u_merge
    (
        .asset_byte (asset_q),
        .frame_byte (frame_q),
        .ctrl       (mctrl),
        .merged     (merged)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pbb_pkg::ST_CLEAR:
            begin
                if (clr_reg == FA_W'(FRAME_BYTES - 1))
                begin
                    state_next = pbb_pkg::ST_IDLE;
                end
            end
            pbb_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    unique case (request.command)
                        pbb_pkg::CMD_LOAD:  state_next = pbb_pkg::ST_WRAP;
                        pbb_pkg::CMD_BLIT:  state_next = pbb_pkg::ST_BSETUP;
                        pbb_pkg::CMD_READ:  state_next = pbb_pkg::ST_FRD1;
                        pbb_pkg::CMD_WRITE: state_next = pbb_pkg::ST_FWRITE;
                    endcase
                end
            end
            pbb_pkg::ST_WRAP:
            begin
                if (!wrap_ge)
                begin
                    state_next = pbb_pkg::ST_IDLE;
                end
            end
            pbb_pkg::ST_FWRITE: state_next = pbb_pkg::ST_IDLE;
            pbb_pkg::ST_FRD1:   state_next = pbb_pkg::ST_FRD2;
            pbb_pkg::ST_FRD2:   state_next = pbb_pkg::ST_IDLE;
            pbb_pkg::ST_BSETUP: state_next = pbb_pkg::ST_BCOL;
            pbb_pkg::ST_BCOL:
            begin
                state_next = col_end ? pbb_pkg::ST_IDLE : pbb_pkg::ST_BRD;
            end
            pbb_pkg::ST_BRD:    state_next = pbb_pkg::ST_BLO;
            pbb_pkg::ST_BLO:
            begin
                if (hi_need)
                begin
                    state_next = pbb_pkg::ST_BHI;
                end
                else
                begin
                    state_next = last_page ? pbb_pkg::ST_BCOL : pbb_pkg::ST_BRD;
                end
            end
            pbb_pkg::ST_BHI:
            begin
                state_next = last_page ? pbb_pkg::ST_BCOL : pbb_pkg::ST_BRD;
            end
            default:            state_next = pbb_pkg::ST_IDLE;
        endcase
    end

    // outputs: memory strobes, counter updates, result word
    always_comb
    begin
        item_next    = item_reg;
        wrap_next    = wrap_reg;
        clr_next     = clr_reg;
        col_cnt_next = col_cnt_reg;
        col_next     = col_reg;
        base_next    = base_reg;
        aidx_next    = aidx_reg;
        page_next    = page_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        fr_re        = 1'b0;
        fr_raddr     = ix_lo[FA_W-1:0];
        fr_we        = 1'b0;
        fr_waddr     = ix_lo[FA_W-1:0];
        fr_wdata     = merged;
        as_re        = 1'b0;
        as_raddr     = aidx_reg[AA_W-1:0];
        as_we        = 1'b0;
        as_waddr     = wrap_reg[AA_W-1:0];
        as_wdata     = item_reg.data;

        unique case (state_reg)
            pbb_pkg::ST_CLEAR:
            begin
                fr_we    = 1'b1;
                fr_waddr = clr_reg;
                fr_wdata = 8'h00;
                clr_next = clr_reg + FA_W'(1);
            end
            pbb_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    item_next = request;
                    wrap_next = WX_W'(request.address);
                end
            end
            pbb_pkg::ST_WRAP:
            begin
                // load index taken modulo the store size by repeated subtract
                if (wrap_ge)
                begin
                    wrap_next = wrap_reg - WX_W'(ASSET_BYTES);
                end
                else
                begin
                    as_we       = 1'b1;
                    done_next   = 1'b1;
                    result_next = '{read_data: 8'h00, done_kind: item_reg.command};
                end
            end
            pbb_pkg::ST_FWRITE:
            begin
                fr_we       = addr_ok;
                fr_waddr    = fx[FA_W-1:0];
                fr_wdata    = item_reg.data;
                done_next   = 1'b1;
                result_next = '{read_data: 8'h00, done_kind: item_reg.command};
            end
            pbb_pkg::ST_FRD1:
            begin
                fr_re    = addr_ok;
                fr_raddr = fx[FA_W-1:0];
            end
            pbb_pkg::ST_FRD2:
            begin
                done_next   = 1'b1;
                result_next = '{read_data: (addr_ok ? frame_q : 8'h00),
                                done_kind: item_reg.command};
            end
            pbb_pkg::ST_BSETUP:
            begin
                col_cnt_next = 8'd0;
                col_next     = {1'b0, item_reg.x_pos};
                base_next    = BASE_W'(item_reg.x_pos) * BASE_W'(PAGES);
                aidx_next    = '0;
            end
            pbb_pkg::ST_BCOL:
            begin
                page_next = 5'd0;
                if (col_end)
                begin
                    done_next   = 1'b1;
                    result_next = '{read_data: 8'h00, done_kind: item_reg.command};
                end
            end
            pbb_pkg::ST_BRD:
            begin
                as_re = aidx_ok;
                fr_re = lo_ok;
            end
            pbb_pkg::ST_BLO:
            begin
                fr_we = aidx_ok && lo_ok;
                if (hi_need)
                begin
                    fr_re    = 1'b1;
                    fr_raddr = ix_hi[FA_W-1:0];
                end
                else
                begin
                    aidx_next = aidx_reg + AI_W'(1);
                    page_next = page_reg + 5'd1;
                    if (last_page)
                    begin
                        col_cnt_next = col_cnt_reg + 8'd1;
                        col_next     = col_reg + 9'd1;
                        base_next    = base_reg + BASE_W'(PAGES);
                    end
                end
            end
            pbb_pkg::ST_BHI:
            begin
                fr_we     = 1'b1;
                fr_waddr  = ix_hi[FA_W-1:0];
                aidx_next = aidx_reg + AI_W'(1);
                page_next = page_reg + 5'd1;
                if (last_page)
                begin
                    col_cnt_next = col_cnt_reg + 8'd1;
                    col_next     = col_reg + 9'd1;
                    base_next    = base_reg + BASE_W'(PAGES);
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pbb_pkg::ST_CLEAR;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        wrap_reg    <= wrap_next;
        col_cnt_reg <= col_cnt_next;
        col_reg     <= col_next;
        base_reg    <= base_next;
        aidx_reg    <= aidx_next;
        page_reg    <= page_next;
        result_reg  <= result_next;
    end

    // frame memory: one write and one read port
    always_ff @(posedge clk)
    begin
        if (fr_we)
        begin
            frame_mem[fr_waddr] <= fr_wdata;
        end
        if (fr_re)
        begin
            frame_q <= frame_mem[fr_raddr];
        end
    end

    // asset memory
    always_ff @(posedge clk)
    begin
        if (as_we)
        begin
            asset_mem[as_waddr] <= as_wdata;
        end
        if (as_re)
        begin
            asset_q <= asset_mem[as_raddr];
        end
    end

    assign busy   = (state_reg != pbb_pkg::ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* design/pbb_checker.sv */
`include "page_bitmap_blit_defines.svh"

module pbb_checker
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input pbb_pkg::pbb_cmd_t    request,
    input logic                 done,
    input pbb_pkg::pbb_result_t result
);

    logic accepted;
    logic non_read_done;

    assign accepted      = start && !busy && (request.command == request.command);
    assign non_read_done = done && (result.done_kind != pbb_pkg::CMD_READ);

    // a taken word always makes the engine busy
    `PBB_ASSERT_NXT(a_accept_busy, accepted, busy)
    // every result word is a single-cycle pulse
    `PBB_ASSERT_NXT(a_done_pulse, done, !done)
    // a result only shows once the engine has gone back to idle
    `PBB_ASSERT_IMP(a_done_idle, done, !busy)
    // only a frame read returns data
    `PBB_ASSERT_IMP(a_zero_data, non_read_done, result.read_data == 8'h00)

endmodule

bind page_bitmap_blit pbb_checker u_pbb_checker
(
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
);

/* tb/sv/tb_page_bitmap_blit.sv */
module tb_page_bitmap_blit;
    timeunit 1ns;
    timeprecision 1ps;

    // geometry of the instance under test
    localparam int COLUMNS     = 128;
    localparam int PAGES       = 8;
    localparam int ASSET_BYTES = 1024;
    localparam int FRAME_BYTES = COLUMNS * PAGES;

    // stimulus shape
    localparam int ASSET_FILL   = 128;  // asset entries loaded up front, blits stay inside
    localparam int RANDOM_WORDS = 430;
    localparam int QUIET_FIRST  = 250;  // no sender gaps in this stretch
    localparam int QUIET_LAST   = 349;
    localparam int DRAIN_EVERY  = 120;  // sender waits for all results this often
    localparam int GAP_PERCENT  = 29;
    localparam int TAIL_CYCLES  = 64;

    // watchdog: clear pass plus every word as the longest legal blit after the
    // longest sender gap comes to about 1.3 ms
    localparam longint WATCHDOG_NS = 64'd10_000_000;

    logic                clk     = 1'b0;
    logic                rst_n   = 1'b0;
    logic                start   = 1'b0;
    logic                busy;
    pbb_pkg::pbb_cmd_t   request = '0;
    logic                done;
    pbb_pkg::pbb_result_t result;

    // one row of the directed table; typed rows carry their read_data inline
    typedef struct {
        pbb_pkg::pbb_cmd_t word;
        bit                typed;
        logic [7:0]        typed_read;
    } stim_row_t;

    // shadow copies of the two stores
    logic [7:0]  frame_img [FRAME_BYTES];
    logic [7:0]  asset_img [ASSET_BYTES];

    pbb_pkg::pbb_result_t due_results [$];
    stim_row_t            dir_rows [$];
    int                   err_count = 0;
    bit                   gaps_on   = 1'b1;

    page_bitmap_blit
    #(
        .COLUMNS     (COLUMNS),
        .PAGES       (PAGES),
        .ASSET_BYTES (ASSET_BYTES)
    )
    u_top
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // OR the asset into the frame image, top-left corner at (x_pos, y_pos)
    function automatic void blit_into_frame(input pbb_pkg::pbb_cmd_t w);
        int          npg;
        int          top_pg;
        int          sh;
        int          tl;
        int          col;
        int          ai;
        int          dp;
        logic [7:0]  msk;
        logic [15:0] shifted;
        npg    = (int'(w.blit_height) + 7) / 8;
        top_pg = int'(w.y_pos) / 8;
        sh     = int'(w.y_pos) % 8;
        tl     = int'(w.blit_height) % 8;
        for (int c = 0; c < int'(w.blit_width); c++)
        begin
            col = int'(w.x_pos) + c;
            // columns past the right edge are never read or written
            if (col >= COLUMNS)
                break;
            for (int p = 0; p < npg; p++)
            begin
                ai = c * npg + p;
                dp = top_pg + p;
                // asset index past the store contributes nothing
                if (ai >= ASSET_BYTES)
                    continue;
                msk = 8'hff;
                // last page of the asset keeps only its tail rows
                if (p == npg - 1 && tl != 0)
                    msk = 8'hff >> (8 - tl);
                shifted = {8'h00, asset_img[ai] & msk} << sh;
                if (dp < PAGES)
                    frame_img[col * PAGES + dp] |= shifted[7:0];
                // lower half of a split byte, dropped past the last page
                if (sh != 0 && dp + 1 < PAGES)
                    frame_img[col * PAGES + dp + 1] |= shifted[15:8];
            end
        end
    endfunction

    // update the shadow stores for one accepted word and return its result
    function automatic pbb_pkg::pbb_result_t process_word(input pbb_pkg::pbb_cmd_t w);
        pbb_pkg::pbb_result_t r;
        r.read_data = 8'h00;
        r.done_kind = w.command;
        case (w.command)
            pbb_pkg::CMD_LOAD:
                asset_img[int'(w.address) % ASSET_BYTES] = w.data;
            pbb_pkg::CMD_BLIT:
                blit_into_frame(w);
            pbb_pkg::CMD_READ:
                if (int'(w.address) < FRAME_BYTES)
                    r.read_data = frame_img[w.address];
            default:
                if (int'(w.address) < FRAME_BYTES)
                    frame_img[w.address] = w.data;
        endcase
        return r;
    endfunction

    function automatic void add_row(input logic [1:0] cmd, input int addr, input int dat,
                                    input int x, input int y, input int wd, input int ht,
                                    input bit typed, input int rd);
        stim_row_t row;
        row.word.command     = cmd;
        row.word.address     = pbb_pkg::ADDR_W'(addr);
        row.word.data        = 8'(dat);
        row.word.x_pos       = 8'(x);
        row.word.y_pos       = 6'(y);
        row.word.blit_width  = 8'(wd);
        row.word.blit_height = 7'(ht);
        row.typed            = typed;
        row.typed_read       = 8'(rd);
        dir_rows.push_back(row);
    endfunction

    // every field random, so unused fields of a command carry noise
    function automatic pbb_pkg::pbb_cmd_t noise_word();
        pbb_pkg::pbb_cmd_t w;
        w.command     = 2'($urandom);
        w.address     = pbb_pkg::ADDR_W'($urandom);
        w.data        = 8'($urandom);
        w.x_pos       = 8'($urandom);
        w.y_pos       = 6'($urandom);
        w.blit_width  = 8'($urandom);
        w.blit_height = 7'($urandom);
        return w;
    endfunction

    // narrow a blit so it reads only the loaded part of the asset store
    function automatic pbb_pkg::pbb_cmd_t fit_blit(input pbb_pkg::pbb_cmd_t w);
        pbb_pkg::pbb_cmd_t f;
        int                npg;
        int                vis;
        f   = w;
        npg = (int'(w.blit_height) + 7) / 8;
        vis = COLUMNS - int'(w.x_pos);
        if (vis < 0)
            vis = 0;
        if (int'(w.blit_width) < vis)
            vis = int'(w.blit_width);
        if (npg != 0 && vis * npg > ASSET_FILL)
            f.blit_width = 8'(ASSET_FILL / npg);
        return f;
    endfunction

    // random mix: loads, blits (mostly small, now and then huge), reads, writes
    function automatic pbb_pkg::pbb_cmd_t random_word();
        pbb_pkg::pbb_cmd_t w;
        int                sel;
        w   = noise_word();
        sel = $urandom_range(99);
        if (sel < 20)
        begin
            w.command = pbb_pkg::CMD_LOAD;
            // sparse assets keep the frame from saturating
            if ($urandom_range(1) == 0)
                w.data = 8'($urandom & $urandom);
        end
        else if (sel < 45)
        begin
            w.command = pbb_pkg::CMD_BLIT;
            if ($urandom_range(9) != 0)
            begin
                w.x_pos       = 8'($urandom_range(0, 135));
                w.blit_width  = 8'($urandom_range(0, 12));
                w.blit_height = 7'($urandom_range(0, 20));
            end
            w = fit_blit(w);
        end
        else if (sel < 80)
        begin
            w.command = pbb_pkg::CMD_READ;
        end
        else
        begin
            w.command = pbb_pkg::CMD_WRITE;
            // clear bytes often so later ORs stay visible
            if ($urandom_range(1) == 0)
                w.data = 8'h00;
        end
        return w;
    endfunction

    // present one word, hold it until taken, then log what it must return
    task automatic send_word(input pbb_pkg::pbb_cmd_t w, input bit typed,
                             input logic [7:0] typed_read);
        pbb_pkg::pbb_result_t r;
        int                   gap;
        if (gaps_on && $urandom_range(99) < GAP_PERCENT)
        begin
            gap   = $urandom_range(1, 8);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= w;
        // busy only moves on the rising edge, so look at it mid-cycle
        do
            @(negedge clk);
        while (busy);
        @(posedge clk);
        r = process_word(w);
        if (typed)
            r.read_data = typed_read;
        due_results.push_back(r);
    endtask

    // sender holds off until every outstanding result is back
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
    endtask

    // result check, sampled mid-cycle while the strobe is steady
    always @(negedge clk)
    begin
        pbb_pkg::pbb_result_t want;
        if (rst_n && done)
        begin
            if (due_results.size() == 0)
            begin
                err_count++;
                $error("result word with none outstanding: read_data %02h done_kind %0d",
                       result.read_data, result.done_kind);
            end
            else
            begin
                want = due_results.pop_front();
                if (result.read_data !== want.read_data)
                begin
                    err_count++;
                    $error("read_data: expected %02h, got %02h", want.read_data,
                           result.read_data);
                end
                if (result.done_kind !== want.done_kind)
                begin
                    err_count++;
                    $error("done_kind: expected %0d, got %0d", want.done_kind,
                           result.done_kind);
                end
            end
        end
    end

    // watchdog
    initial
    begin
        #(WATCHDOG_NS);
        $display("FAIL page_bitmap_blit");
        $finish;
    end

    initial
    begin
        pbb_pkg::pbb_cmd_t w;

        foreach (frame_img[i])
            frame_img[i] = 8'h00;
        foreach (asset_img[i])
            asset_img[i] = 8'h00;

        // directed table: cmd, address, data, x, y, width, height, typed, read_data
        // frame is all zeros after reset, the load fill does not touch it
        add_row(pbb_pkg::CMD_READ,  0,    0,     0,   0,  0,   0,   1, 8'h00);
        add_row(pbb_pkg::CMD_READ,  1023, 0,     0,   0,  0,   0,   1, 8'h00);
        add_row(pbb_pkg::CMD_WRITE, 1023, 8'hff, 0,   0,  0,   0,   1, 8'h00);
        add_row(pbb_pkg::CMD_READ,  1023, 0,     0,   0,  0,   0,   1, 8'hff);
        add_row(pbb_pkg::CMD_WRITE, 5,    8'ha5, 0,   0,  0,   0,   1, 8'h00);
        add_row(pbb_pkg::CMD_READ,  5,    0,     0,   0,  0,   0,   1, 8'ha5);
        add_row(pbb_pkg::CMD_LOAD,  0,    8'hff, 0,   0,  0,   0,   1, 8'h00);
        add_row(pbb_pkg::CMD_LOAD,  1023, 8'h00, 0,   0,  0,   0,   1, 8'h00);
        // zero width and zero height leave the frame alone
        add_row(pbb_pkg::CMD_BLIT,  0,    0,     0,   0,  0,   64,  1, 8'h00);
        add_row(pbb_pkg::CMD_BLIT,  0,    0,     0,   0,  128, 0,   1, 8'h00);
        add_row(pbb_pkg::CMD_READ,  0,    0,     0,   0,  0,   0,   1, 8'h00);
        // aligned single byte
        add_row(pbb_pkg::CMD_BLIT,  0,    0,     0,   0,  1,   8,   1, 8'h00);
        add_row(pbb_pkg::CMD_READ,  0,    0,     0,   0,  0,   0,   0, 8'h00);
        // tail mask with a byte split across two pages
        add_row(pbb_pkg::CMD_BLIT,  0,    0,     3,   6,  2,   3,   1, 8'h00);
        add_row(pbb_pkg::CMD_READ,  24,   0,     0,   0,  0,   0,   0, 8'h00);
        add_row(pbb_pkg::CMD_READ,  25,   0,     0,   0,  0,   0,   0, 8'h00);
        // clipped at the right edge and below the last page
        add_row(pbb_pkg::CMD_BLIT,  0,    0,     124, 60, 128, 64,  1, 8'h00);
        add_row(pbb_pkg::CMD_READ,  1023, 0,     0,   0,  0,   0,   0, 8'h00);
        add_row(pbb_pkg::CMD_READ,  1016, 0,     0,   0,  0,   0,   0, 8'h00);
        // entirely off screen
        add_row(pbb_pkg::CMD_BLIT,  0,    0,     255, 63, 255, 127, 1, 8'h00);
        // 16 pages tall: the lower pages fall off the bottom of the frame
        add_row(pbb_pkg::CMD_BLIT,  0,    0,     0,   1,  8,   127, 1, 8'h00);
        add_row(pbb_pkg::CMD_READ,  7,    0,     0,   0,  0,   0,   0, 8'h00);
        add_row(pbb_pkg::CMD_READ,  9,    0,     0,   0,  0,   0,   0, 8'h00);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // load the front of the asset store, every blit stays inside it
        for (int i = 0; i < ASSET_FILL; i++)
        begin
            w         = noise_word();
            w.command = pbb_pkg::CMD_LOAD;
            w.address = pbb_pkg::ADDR_W'(i);
            w.data    = 8'($urandom & $urandom);
            send_word(w, 1'b1, 8'h00);
        end

        foreach (dir_rows[i])
            send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].typed_read);

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            gaps_on = !(n >= QUIET_FIRST && n <= QUIET_LAST);
            if (n % DRAIN_EVERY == DRAIN_EVERY - 1)
                drain_results();
            send_word(random_word(), 1'b0, 8'h00);
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("PASS page_bitmap_blit");
        else
            $display("FAIL page_bitmap_blit");
        $finish;
    end

endmodule

/* page_bitmap_blit.f */
+incdir+design
design/pbb_pkg.sv
design/pbb_merge.sv
design/page_bitmap_blit.sv
design/pbb_checker.sv
tb/sv/tb_page_bitmap_blit.sv
